// ----- rtl/core/ati_pkg.sv -----
// ----------------------------------------------------------------------------
// ati_pkg
// shared lane indexes and the side-band record of the affine inverse pipeline
// ----------------------------------------------------------------------------
package ati_pkg;

   localparam int NUM_COEF = 6;

   // lane order of the six inverse coefficients
   localparam int LANE_XX    = 0;
   localparam int LANE_XY    = 1;
   localparam int LANE_OFF_X = 2;
   localparam int LANE_YX    = 3;
   localparam int LANE_YY    = 4;
   localparam int LANE_OFF_Y = 5;

   typedef struct packed {
      logic [NUM_COEF-1:0] neg;
      logic                singular;
   } side_type;

endpackage

// ----- rtl/core/affine_transform_inverse_core.sv -----
// ----------------------------------------------------------------------------
// affine_transform_inverse_core
// inverse of a 2d affine transform in signed fixed point
// ----------------------------------------------------------------------------
// Takes one transform per cycle and returns one inverse per cycle while the
// output is not stalled: four stages register the input, form the products,
// the determinant and offset numerators, and the magnitudes; six restoring
// dividers then take one stage per quotient bit plus a range check stage; a
// last stage saturates, applies the sign and substitutes the identity for a
// zero determinant. The whole pipeline holds while a result waits, so
// req_tready is low only while rsp_tvalid is high and rsp_tready is low.
module affine_transform_inverse_core #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // lin_xx, lin_xy, offset_x, lin_yx, lin_yy, offset_y
   input  logic [((6*WORD_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // inv_xx, inv_xy, inv_offset_x, inv_yx, inv_yy, inv_offset_y
   output logic [((6*WORD_BITS+7)/8)*8-1:0]      rsp_tdata,
   // singular, overflow
   output logic [1:0]                            rsp_tuser
);

   localparam int W        = WORD_BITS;
   localparam int PW       = 2 * WORD_BITS;
   localparam int DW       = PW + 1;
   localparam int LIN_NB   = WORD_BITS + 2 * FRAC_BITS;
   localparam int OFF_NB   = PW + FRAC_BITS;
   localparam int NUM_BITS = (LIN_NB > OFF_NB) ? LIN_NB : OFF_NB;
   localparam int LAST     = WORD_BITS + 5;
   localparam bit ONE_SAT  = (FRAC_BITS >= WORD_BITS - 1);
   localparam logic [W-1:0] WMAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] ONE_VAL = ONE_SAT ? WMAX : (W'(1) << FRAC_BITS);

   logic ce;
   logic [LAST:0] vld_ff;

   logic signed [W-1:0]  a_ff, b_ff, c_ff, d_ff, e_ff, f_ff;
   logic signed [PW-1:0] p_ae_ff, p_bd_ff, p_bf_ff, p_ce_ff, p_cd_ff, p_af_ff;
   logic signed [W:0]    lin1_ff [4];
   logic signed [DW-1:0] det2_ff, offx2_ff, offy2_ff;
   logic signed [W:0]    lin2_ff [4];

   logic [NUM_BITS-1:0] num3_ff [ati_pkg::NUM_COEF];
   logic [PW-1:0]       den3_ff;
   ati_pkg::side_type   side3_ff;

   logic [W-1:0]      q_w   [ati_pkg::NUM_COEF];
   logic              big_w [ati_pkg::NUM_COEF];
   ati_pkg::side_type side_w;

   logic [W-1:0] res_in [ati_pkg::NUM_COEF];
   logic         ovf_in;
   logic [W-1:0] res_ff [ati_pkg::NUM_COEF];
   logic         sing_ff;
   logic         ovf_ff;

   assign ce         = !vld_ff[LAST] || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[LAST-1:0], req_tvalid};
      end
   end

   // stage 0: input register
   always_ff @(posedge clock) begin
      if (ce) begin
         a_ff <= req_tdata[0*W +: W];
         b_ff <= req_tdata[1*W +: W];
         c_ff <= req_tdata[2*W +: W];
         d_ff <= req_tdata[3*W +: W];
         e_ff <= req_tdata[4*W +: W];
         f_ff <= req_tdata[5*W +: W];
      end
   end

   // stage 1: products and linear numerators e, -b, -d, a
   always_ff @(posedge clock) begin
      if (ce) begin
         p_ae_ff <= a_ff * e_ff;
         p_bd_ff <= b_ff * d_ff;
         p_bf_ff <= b_ff * f_ff;
         p_ce_ff <= c_ff * e_ff;
         p_cd_ff <= c_ff * d_ff;
         p_af_ff <= a_ff * f_ff;
         lin1_ff[0] <= (W+1)'(e_ff);
         lin1_ff[1] <= -(W+1)'(b_ff);
         lin1_ff[2] <= -(W+1)'(d_ff);
         lin1_ff[3] <= (W+1)'(a_ff);
      end
   end

   // stage 2: determinant and offset numerators
   always_ff @(posedge clock) begin
      if (ce) begin
         det2_ff  <= DW'(p_ae_ff) - DW'(p_bd_ff);
         offx2_ff <= DW'(p_bf_ff) - DW'(p_ce_ff);
         offy2_ff <= DW'(p_cd_ff) - DW'(p_af_ff);
         lin2_ff  <= lin1_ff;
      end
   end

   // stage 3: magnitudes, aligned numerators and signs
   always_ff @(posedge clock) begin
      if (ce) begin
         den3_ff <= PW'(det2_ff[DW-1] ? -det2_ff : det2_ff);
         side3_ff.singular <= (det2_ff == '0);
         num3_ff[ati_pkg::LANE_XX] <= NUM_BITS'({W'(lin2_ff[0][W] ? -lin2_ff[0] : lin2_ff[0]),
                                                 {(2*FRAC_BITS){1'b0}}});
         num3_ff[ati_pkg::LANE_XY] <= NUM_BITS'({W'(lin2_ff[1][W] ? -lin2_ff[1] : lin2_ff[1]),
                                                 {(2*FRAC_BITS){1'b0}}});
         num3_ff[ati_pkg::LANE_YX] <= NUM_BITS'({W'(lin2_ff[2][W] ? -lin2_ff[2] : lin2_ff[2]),
                                                 {(2*FRAC_BITS){1'b0}}});
         num3_ff[ati_pkg::LANE_YY] <= NUM_BITS'({W'(lin2_ff[3][W] ? -lin2_ff[3] : lin2_ff[3]),
                                                 {(2*FRAC_BITS){1'b0}}});
         num3_ff[ati_pkg::LANE_OFF_X] <= NUM_BITS'({PW'(offx2_ff[DW-1] ? -offx2_ff : offx2_ff),
                                                    {FRAC_BITS{1'b0}}});
         num3_ff[ati_pkg::LANE_OFF_Y] <= NUM_BITS'({PW'(offy2_ff[DW-1] ? -offy2_ff : offy2_ff),
                                                    {FRAC_BITS{1'b0}}});
         side3_ff.neg[ati_pkg::LANE_XX]    <= lin2_ff[0][W] ^ det2_ff[DW-1];
         side3_ff.neg[ati_pkg::LANE_XY]    <= lin2_ff[1][W] ^ det2_ff[DW-1];
         side3_ff.neg[ati_pkg::LANE_YX]    <= lin2_ff[2][W] ^ det2_ff[DW-1];
         side3_ff.neg[ati_pkg::LANE_YY]    <= lin2_ff[3][W] ^ det2_ff[DW-1];
         side3_ff.neg[ati_pkg::LANE_OFF_X] <= offx2_ff[DW-1] ^ det2_ff[DW-1];
         side3_ff.neg[ati_pkg::LANE_OFF_Y] <= offy2_ff[DW-1] ^ det2_ff[DW-1];
      end
   end

   ati_div_lanes #(
      .WORD_BITS (WORD_BITS),
      .NUM_BITS  (NUM_BITS),
      .DEN_BITS  (PW)
   ) u_div (
      .clock  (clock),
      .ce_i   (ce),
      .num_i  (num3_ff),
      .den_i  (den3_ff),
      .side_i (side3_ff),
      .q_o    (q_w),
      .big_o  (big_w),
      .side_o (side_w)
   );

   // saturate, sign and identity substitution
   always_comb begin
      logic [W-1:0] limit;
      logic [W-1:0] qs;
      logic         sat;
      ovf_in = 1'b0;
      for (int l = 0; l < ati_pkg::NUM_COEF; l++) begin
         limit = WMAX + W'(side_w.neg[l]);
         sat   = big_w[l] || (q_w[l] > limit);
         qs    = sat ? limit : q_w[l];
         res_in[l] = side_w.neg[l] ? -qs : qs;
         ovf_in = ovf_in | sat;
      end
      if (side_w.singular) begin
         for (int l = 0; l < ati_pkg::NUM_COEF; l++) begin
            res_in[l] = '0;
         end
         res_in[ati_pkg::LANE_XX] = ONE_VAL;
         res_in[ati_pkg::LANE_YY] = ONE_VAL;
         ovf_in = ONE_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         res_ff  <= res_in;
         sing_ff <= side_w.singular;
         ovf_ff  <= ovf_in;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int l = 0; l < ati_pkg::NUM_COEF; l++) begin
         rsp_tdata[l*W +: W] = res_ff[l];
      end
   end

   assign rsp_tuser = {ovf_ff, sing_ff};

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted beat did not enter the pipeline");

   a_singular_offdiag : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata[1*W +: W] == '0 && rsp_tdata[2*W +: W] == '0 &&
          rsp_tdata[3*W +: W] == '0 && rsp_tdata[5*W +: W] == '0))
      else $error("singular beat with nonzero off-diagonal term");

   a_singular_no_ovf : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] && !ONE_SAT) |-> !rsp_tuser[1])
      else $error("singular beat flagged overflow");

endmodule

// ----- rtl/core/ati_div_lanes.sv -----
// ----------------------------------------------------------------------------
// ati_div_lanes
// six pipelined restoring dividers sharing one denominator, one quotient bit
// per stage, with the side-band record carried alongside
// ----------------------------------------------------------------------------
module ati_div_lanes #(
   parameter int WORD_BITS = 32,
   parameter int NUM_BITS  = 80,
   parameter int DEN_BITS  = 64
) (
   input  logic                 clock,
   input  logic                 ce_i,
   input  logic [NUM_BITS-1:0]  num_i [ati_pkg::NUM_COEF],
   input  logic [DEN_BITS-1:0]  den_i,
   input  ati_pkg::side_type    side_i,
   output logic [WORD_BITS-1:0] q_o   [ati_pkg::NUM_COEF],
   output logic                 big_o [ati_pkg::NUM_COEF],
   output ati_pkg::side_type    side_o
);

   localparam int QB = WORD_BITS;
   localparam int CW = ((NUM_BITS > DEN_BITS + QB) ? NUM_BITS : DEN_BITS + QB) + 1;

   logic [NUM_BITS-1:0] rem_ff  [ati_pkg::NUM_COEF][QB+1];
   logic [QB-1:0]       q_ff    [ati_pkg::NUM_COEF][QB+1];
   logic                big_ff  [ati_pkg::NUM_COEF][QB+1];
   logic [DEN_BITS-1:0] den_ff  [QB+1];
   ati_pkg::side_type   side_ff [QB+1];

   always_ff @(posedge clock) begin
      if (ce_i) begin
         den_ff[0]  <= den_i;
         side_ff[0] <= side_i;
         for (int l = 0; l < ati_pkg::NUM_COEF; l++) begin
            rem_ff[l][0] <= num_i[l];
            q_ff[l][0]   <= '0;
            // quotient would need more than QB bits
            big_ff[l][0] <= CW'(num_i[l]) >= (CW'(den_i) << QB);
         end
         for (int s = 1; s <= QB; s++) begin
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
            for (int l = 0; l < ati_pkg::NUM_COEF; l++) begin
               big_ff[l][s] <= big_ff[l][s-1];
               if (CW'(rem_ff[l][s-1]) >= (CW'(den_ff[s-1]) << (QB - s))) begin
                  rem_ff[l][s] <= NUM_BITS'(CW'(rem_ff[l][s-1])
                                            - (CW'(den_ff[s-1]) << (QB - s)));
                  q_ff[l][s]   <= q_ff[l][s-1] | (QB'(1) << (QB - s));
               end else begin
                  rem_ff[l][s] <= rem_ff[l][s-1];
                  q_ff[l][s]   <= q_ff[l][s-1];
               end
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < ati_pkg::NUM_COEF; l++) begin
         q_o[l]   = q_ff[l][QB];
         big_o[l] = big_ff[l][QB];
      end
   end

   assign side_o = side_ff[QB];

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for affine_transform_inverse_core
// ----------------------------------------------------------------------------
// Drives six-coefficient transforms through the req stream and checks every
// inverse on the rsp stream against an exact wide-integer inverse computed
// here. A directed table covers identity, zero determinant, saturation and the
// word extremes. Random transforms follow (full range, near-unit, singular),
// with bursty input, a patterned output stall, one long output hold-off and
// one drain pause.
// ----------------------------------------------------------------------------
module tb;

   localparam int W = 32;
   localparam int F = 16;
   localparam int DW = ((6*W+7)/8)*8;
   localparam int NUM_ITEMS = 900;
   localparam int LATENCY = W + 6;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE = 1 <<< F;

   typedef logic signed [W-1:0] word_type;

   typedef struct {
      word_type coef [ati_pkg::NUM_COEF];
   } xform_type;

   typedef struct {
      word_type coef [ati_pkg::NUM_COEF];
      logic     singular;
      logic     overflow;
   } inverse_type;

   typedef struct {
      xform_type   xf;
      logic        known;
      inverse_type inv;
   } row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;
   logic [1:0]    rsp_tuser;

   inverse_type pending_inverses [$];
   int          errors = 0;
   int          n_checked = 0;
   int          n_singular = 0;
   int          n_overflow = 0;
   int          cycles = 0;
   bit          hold_off = 1'b0;
   row_type     table_rows [$];
   string       lane_name [ati_pkg::NUM_COEF] = '{"inv_xx", "inv_xy", "inv_offset_x",
                                                 "inv_yx", "inv_yy", "inv_offset_y"};

   affine_transform_inverse_core #(.WORD_BITS(W), .FRAC_BITS(F)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact inverse: numerators over the full-precision determinant
   function automatic inverse_type invert(xform_type t);
      logic signed [127:0] a, b, c, d, e, f, det, q;
      logic signed [127:0] num [ati_pkg::NUM_COEF];
      inverse_type r;
      a = t.coef[0]; b = t.coef[1]; c = t.coef[2];
      d = t.coef[3]; e = t.coef[4]; f = t.coef[5];
      det = a*e - b*d;
      r.overflow = 1'b0;
      r.singular = (det == 0);
      if (r.singular) begin
         foreach (r.coef[k]) r.coef[k] = '0;
         r.coef[ati_pkg::LANE_XX] = ONE;
         r.coef[ati_pkg::LANE_YY] = ONE;
         return r;
      end
      num[ati_pkg::LANE_XX]    = e <<< (2*F);
      num[ati_pkg::LANE_XY]    = (-b) <<< (2*F);
      num[ati_pkg::LANE_OFF_X] = (b*f - c*e) <<< F;
      num[ati_pkg::LANE_YX]    = (-d) <<< (2*F);
      num[ati_pkg::LANE_YY]    = a <<< (2*F);
      num[ati_pkg::LANE_OFF_Y] = (c*d - a*f) <<< F;
      for (int k = 0; k < ati_pkg::NUM_COEF; k++) begin
         q = num[k] / det;
         if (q > 128'(WMAX)) begin
            r.coef[k] = WMAX;
            r.overflow = 1'b1;
         end else if (q < 128'(WMIN)) begin
            r.coef[k] = WMIN;
            r.overflow = 1'b1;
         end else begin
            r.coef[k] = q[W-1:0];
         end
      end
      return r;
   endfunction

   function automatic xform_type xf6(word_type a, word_type b, word_type c, word_type d,
                                     word_type e, word_type f);
      xform_type t;
      t.coef = '{a, b, c, d, e, f};
      return t;
   endfunction

   function automatic word_type rand_word();
      return word_type'($urandom);
   endfunction

   // small magnitudes around unity so most inverses stay in range
   function automatic word_type rand_near();
      return word_type'($signed($urandom_range(0, 2*8*65536)) - 8*65536);
   endfunction

   function automatic xform_type rand_xform();
      xform_type t;
      int        kind;
      word_type  k;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < ati_pkg::NUM_COEF; i++)
         t.coef[i] = (kind < 3) ? rand_word() : rand_near();
      if (kind == 9) begin
         // rows proportional: zero determinant
         k = word_type'($signed($urandom_range(0, 8)) - 4);
         t.coef[3] = t.coef[0] * k;
         t.coef[4] = t.coef[1] * k;
      end else if (kind == 8) begin
         t.coef[0] = word_type'($signed($urandom_range(0, 64)) - 32);
         t.coef[4] = word_type'($signed($urandom_range(0, 64)) - 32);
      end
      return t;
   endfunction

   task automatic add_row(xform_type t, logic known, inverse_type inv);
      row_type r;
      r.xf = t;
      r.known = known;
      r.inv = inv;
      table_rows.push_back(r);
   endtask

   task automatic send(xform_type t, logic known, inverse_type inv);
      req_tvalid <= 1'b1;
      req_tdata <= DW'({t.coef[5], t.coef[4], t.coef[3], t.coef[2], t.coef[1],
                        t.coef[0]});
      do @(posedge clock); while (!req_tready);
      pending_inverses.push_back(known ? inv : invert(t));
   endtask

   // result checker and output stall pattern
   always @(posedge clock) begin : rsp_side
      inverse_type exp_inv;
      word_type    got;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_inverses.size() == 0) begin
            $display("%0t: unexpected beat tdata=%h tuser=%b", $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_inv = pending_inverses.pop_front();
            n_checked++;
            n_singular += exp_inv.singular;
            n_overflow += exp_inv.overflow;
            for (int k = 0; k < ati_pkg::NUM_COEF; k++) begin
               got = rsp_tdata[k*W +: W];
               if (got !== exp_inv.coef[k]) begin
                  $display("%0t: %s expected %h actual %h", $time, lane_name[k],
                           exp_inv.coef[k], got);
                  errors++;
               end
            end
            if (rsp_tuser[0] !== exp_inv.singular) begin
               $display("%0t: singular expected %b actual %b", $time, exp_inv.singular,
                        rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[1] !== exp_inv.overflow) begin
               $display("%0t: overflow expected %b actual %b", $time, exp_inv.overflow,
                        rsp_tuser[1]);
               errors++;
            end
         end
      end
   end

   initial begin : rsp_stall
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         case ($urandom_range(0, 3))
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= cycles[2];
            default: rsp_tready <= ($urandom_range(0, 1) != 0);
         endcase
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  pending_inverses.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : req_side
      inverse_type ident, sat_diag, dummy;
      int          burst;
      foreach (ident.coef[k]) ident.coef[k] = '0;
      ident.coef[ati_pkg::LANE_XX] = ONE;
      ident.coef[ati_pkg::LANE_YY] = ONE;
      ident.singular = 1'b0;
      ident.overflow = 1'b0;
      sat_diag = ident;
      sat_diag.coef[ati_pkg::LANE_XX] = WMAX;
      sat_diag.coef[ati_pkg::LANE_YY] = WMAX;
      sat_diag.overflow = 1'b1;
      dummy = ident;

      // directed rows
      add_row(xf6(0, 0, 0, 0, 0, 0), 1'b1, '{coef: ident.coef, singular: 1, overflow: 0});
      add_row(xf6(ONE, 0, 0, 0, ONE, 0), 1'b1, ident);
      add_row(xf6(1, 0, 0, 0, 1, 0), 1'b1, sat_diag);
      add_row(xf6(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX), 1'b1,
              '{coef: ident.coef, singular: 1, overflow: 0});
      add_row(xf6(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN), 1'b1,
              '{coef: ident.coef, singular: 1, overflow: 0});
      add_row(xf6(WMIN, 0, WMAX, 0, WMIN, WMIN), 1'b0, dummy);
      add_row(xf6(WMAX, 0, WMIN, 0, WMAX, WMAX), 1'b0, dummy);
      add_row(xf6(WMIN, WMAX, WMIN, WMAX, WMIN, WMAX), 1'b0, dummy);
      add_row(xf6(WMAX, WMIN, 1, -1, WMAX, -1), 1'b0, dummy);
      add_row(xf6(2*ONE, 0, 3*ONE, 0, -4*ONE, -ONE), 1'b0, dummy);
      add_row(xf6(0, ONE, 5*ONE, -ONE, 0, -7*ONE), 1'b0, dummy);
      add_row(xf6(-1, 0, WMAX, 0, 1, WMIN), 1'b0, dummy);
      add_row(xf6(3, 5, 7, 11, 13, 17), 1'b0, dummy);
      add_row(xf6(ONE, ONE, 0, ONE, ONE, 0), 1'b1,
              '{coef: ident.coef, singular: 1, overflow: 0});
      add_row(xf6(-1, -1, -1, -1, -1, -1), 1'b1,
              '{coef: ident.coef, singular: 1, overflow: 0});
      add_row(xf6(WMAX, 0, 0, 0, WMAX, 0), 1'b0, dummy);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[i]) send(table_rows[i].xf, table_rows[i].known, table_rows[i].inv);

      burst = 0;
      for (int n = 0; n < NUM_ITEMS; n++) begin
         if (n == 300) hold_off = 1'b1;
         if (n == 600) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_inverses.size() != 0) @(posedge clock);
         end else if (burst == 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 1)) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
         burst--;
         send(rand_xform(), 1'b0, dummy);
      end
      req_tvalid <= 1'b0;

      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (2*LATENCY) @(posedge clock);

      $display("checked %0d inverses: %0d singular, %0d saturated", n_checked, n_singular,
               n_overflow);
      $display("under bursty input, random output stalls, a long hold-off and a drain");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/ati_pkg.sv
rtl/core/ati_div_lanes.sv
rtl/core/affine_transform_inverse_core.sv
tb/tb.sv
